### design/vgsr_pkg.sv
// ----------------------------------------------------------------------------
// vgsr_pkg: shared types and constants of the glyph string rasterizer
// Request and result beats, command/status bundles and request codes.
// ----------------------------------------------------------------------------
package vgsr_pkg;

    // request codes
    localparam logic [1:0] REQ_CLEAR   = 2'd0;
    localparam logic [1:0] REQ_DECLARE = 2'd1;
    localparam logic [1:0] REQ_DATA    = 2'd2;
    localparam logic [1:0] REQ_READ    = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_OUTSIDE = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_NODATA  = 2'd3;

    localparam logic [14:0] WIDTH_LIMIT = 15'd32767;
    localparam logic [5:0]  PAGE_LIMIT  = 6'd63;
    localparam logic [3:0]  GAP_RESET   = 4'd2;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  glyph_width;
        logic [7:0]  glyph_height;
        logic [7:0]  glyph_length;
        logic [7:0]  data_byte;
        logic [11:0] read_address;
    } t_req;

    typedef struct packed {
        logic [7:0]  read_data;
        logic [14:0] total_width;
        logic [7:0]  total_height;
        logic [1:0]  status;
    } t_res;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic clear_init;
        logic clear_step;
        logic declare;
        logic tab_rd;
        logic skip;
        logic bit_init;
        logic bit_calc;
        logic drop;
        logic mem_rd;
        logic mem_wr;
        logic bit_next;
        logic advance;
        logic set_nodata;
        logic read_issue;
        logic read_take;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic       clr_last;
        logic [1:0] req_type;
        logic       no_glyph;
        logic       len_zero;
        logic       bit_set;
        logic       page_full;
        logic       idx_out;
        logic       bit_last;
    } t_stat;

    // clamp a grown width to the width limit
    function automatic logic [14:0] sat_width(input logic [15:0] v);
        logic [14:0] r;
        r = (v > {1'b0, WIDTH_LIMIT}) ? WIDTH_LIMIT : v[14:0];
        return r;
    endfunction

endpackage

### design/vgsr_dp.sv
// ----------------------------------------------------------------------------
// vgsr_dp: datapath of the glyph string rasterizer
// Glyph tables, string counters, bitmap memory and pixel address arithmetic.
// ----------------------------------------------------------------------------
module vgsr_dp
    import vgsr_pkg::*;
#(
    parameter int BITMAP_BYTES = 4096,
    parameter int MAX_GLYPHS   = 128
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_req       i_req,
    input  logic       i_cfg_we,
    input  logic [3:0] i_cfg_data,
    input  t_cmd       i_cmd,
    output t_stat      o_stat,
    output t_res       o_res
);
    localparam int AW = $clog2(BITMAP_BYTES);
    localparam int GW = (MAX_GLYPHS > 1) ? $clog2(MAX_GLYPHS) : 1;

    logic [7:0] mem_bitmap [BITMAP_BYTES];
    logic [7:0] mem_gw     [MAX_GLYPHS];
    logic [7:0] mem_gl     [MAX_GLYPHS];

    t_req        r_req;
    logic [3:0]  r_gap;
    logic [7:0]  r_count, r_rg, r_byte, r_col, r_hmax;
    logic [5:0]  r_page;
    logic [14:0] r_wsum, r_pen;
    logic [2:0]  r_bit;
    logic [22:0] r_idx;
    logic [1:0]  r_status;
    logic [7:0]  r_rdata, r_mem_q, r_tw_q, r_tl_q;
    logic [AW-1:0] r_clr;

    logic [15:0] x_pos;
    logic [12:0] stride;
    logic [8:0]  y_pos;
    logic [7:0]  eff_w;
    logic [7:0]  col_inc, byte_inc;
    logic [14:0] pen_next;
    logic [16:0] raddr_ext;
    logic [AW-1:0] mem_raddr;

    // pixel address terms
    always_comb begin
        x_pos     = {1'b0, r_pen} + 16'(r_col);
        stride    = 13'((16'(r_wsum) + 16'd7) >> 3);
        y_pos     = {r_page, r_bit};
        eff_w     = (r_tw_q == 8'd0) ? 8'd1 : r_tw_q;
        col_inc   = r_col + 8'd1;
        byte_inc  = r_byte + 8'd1;
        pen_next  = sat_width(16'(r_pen) + 16'(r_tw_q) + 16'(r_gap));
        raddr_ext = 17'(r_req.read_address);
        mem_raddr = i_cmd.read_issue ? raddr_ext[AW-1:0] : r_idx[AW-1:0];
    end

    // bitmap memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_step) begin
            mem_bitmap[r_clr] <= 8'h00;
        end else if (i_cmd.mem_wr) begin
            mem_bitmap[r_idx[AW-1:0]] <= r_mem_q | (8'h80 >> x_pos[2:0]);
        end
        if (i_cmd.mem_rd || i_cmd.read_issue) begin
            r_mem_q <= mem_bitmap[mem_raddr];
        end
    end

    // glyph tables
    always_ff @(posedge i_clk) begin
        if (i_cmd.declare && r_count < 8'(MAX_GLYPHS)) begin
            mem_gw[r_count[GW-1:0]] <= r_req.glyph_width;
            mem_gl[r_count[GW-1:0]] <= r_req.glyph_length;
        end
        if (i_cmd.tab_rd) begin
            r_tw_q <= mem_gw[r_rg[GW-1:0]];
            r_tl_q <= mem_gl[r_rg[GW-1:0]];
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_req <= i_req;
        end
        if (i_cmd.bit_calc) begin
            r_idx <= 23'(stride * y_pos) + 23'(x_pos[15:3]);
        end
    end

    // counters and result state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap    <= GAP_RESET;
            r_count  <= '0;
            r_wsum   <= '0;
            r_hmax   <= '0;
            r_rg     <= '0;
            r_byte   <= '0;
            r_col    <= '0;
            r_page   <= '0;
            r_pen    <= '0;
            r_clr    <= '0;
            r_bit    <= '0;
            r_status <= ST_OK;
            r_rdata  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_gap <= i_cfg_data;
            end
            if (i_cmd.accept) begin
                r_status <= ST_OK;
                r_rdata  <= '0;
            end
            if (i_cmd.clear_init) begin
                r_count <= '0;
                r_wsum  <= '0;
                r_hmax  <= '0;
                r_rg    <= '0;
                r_byte  <= '0;
                r_col   <= '0;
                r_page  <= '0;
                r_pen   <= '0;
                r_clr   <= '0;
            end
            if (i_cmd.clear_step) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cmd.declare) begin
                if (r_count >= 8'(MAX_GLYPHS)) begin
                    r_status <= ST_FULL;
                end else begin
                    r_count <= r_count + 8'd1;
                    r_wsum  <= sat_width(16'(r_wsum) + 16'(r_req.glyph_width)
                                         + 16'(r_gap));
                    if (r_req.glyph_height > r_hmax) begin
                        r_hmax <= r_req.glyph_height;
                    end
                end
            end
            if (i_cmd.set_nodata) begin
                r_status <= ST_NODATA;
            end
            if (i_cmd.bit_init) begin
                r_bit <= '0;
            end
            // flag pixels that fall on the last page or outside the store
            if (i_cmd.drop || (i_cmd.bit_next && o_stat.bit_set && o_stat.page_full)) begin
                r_status <= ST_OUTSIDE;
            end
            if (i_cmd.bit_next) begin
                r_bit <= r_bit + 3'd1;
            end
            if (i_cmd.read_take) begin
                r_rdata <= (raddr_ext < 17'(BITMAP_BYTES)) ? r_mem_q : 8'h00;
            end
            // advance the pen past a finished or empty glyph
            if (i_cmd.skip || (i_cmd.advance && byte_inc >= r_tl_q)) begin
                r_pen  <= pen_next;
                r_rg   <= r_rg + 8'd1;
                r_byte <= '0;
                r_col  <= '0;
                r_page <= '0;
            end else if (i_cmd.advance) begin
                r_byte <= byte_inc;
                if (col_inc >= eff_w) begin
                    r_col <= '0;
                    if (r_page < PAGE_LIMIT) begin
                        r_page <= r_page + 6'd1;
                    end
                end else begin
                    r_col <= col_inc;
                end
            end
        end
    end

    always_comb begin
        o_stat.clr_last  = (r_clr == AW'(BITMAP_BYTES - 1));
        // the controller decodes the incoming beat at the accepting edge
        o_stat.req_type  = i_req.req_type;
        o_stat.no_glyph  = (r_rg >= r_count);
        o_stat.len_zero  = (r_tl_q == 8'd0);
        o_stat.bit_set   = r_req.data_byte[r_bit];
        o_stat.page_full = (r_page >= PAGE_LIMIT);
        o_stat.idx_out   = (r_idx >= 23'(BITMAP_BYTES));
        o_stat.bit_last  = (r_bit == 3'd7);

        o_res.read_data    = r_rdata;
        o_res.total_width  = r_wsum;
        o_res.total_height = r_hmax;
        o_res.status       = r_status;
    end

endmodule

### design/vgsr_ctrl.sv
// ----------------------------------------------------------------------------
// vgsr_ctrl: sequencer of the glyph string rasterizer
// Steps each request through clear, declare, table fetch, per-pixel read-modify-write or store read.
// ----------------------------------------------------------------------------
module vgsr_ctrl
    import vgsr_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_busy,
    output logic  o_done
);
    typedef enum logic [3:0] {
        S_IDLE, S_CLR, S_DECL, S_FETCH, S_TAB, S_BIT, S_CHK, S_WR, S_ADV,
        S_RD, S_RDW, S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_report;

    // decode commands and next state
    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.accept = 1'b1;
                    case (i_stat.req_type)
                        REQ_CLEAR:   begin o_cmd.clear_init = 1'b1; n_state = S_CLR; end
                        REQ_DECLARE: n_state = S_DECL;
                        REQ_DATA:    n_state = S_FETCH;
                        default:     n_state = S_RD;
                    endcase
                end
            end
            S_CLR: begin
                o_cmd.clear_step = 1'b1;
                if (i_stat.clr_last) n_state = r_report ? S_DONE : S_IDLE;
            end
            S_DECL: begin
                o_cmd.declare = 1'b1;
                n_state = S_DONE;
            end
            S_FETCH: begin
                if (i_stat.no_glyph) begin
                    o_cmd.set_nodata = 1'b1;
                    n_state = S_DONE;
                end else begin
                    o_cmd.tab_rd = 1'b1;
                    n_state = S_TAB;
                end
            end
            S_TAB: begin
                if (i_stat.len_zero) begin
                    o_cmd.skip = 1'b1;
                    n_state = S_FETCH;
                end else begin
                    o_cmd.bit_init = 1'b1;
                    n_state = S_BIT;
                end
            end
            S_BIT: begin
                if (i_stat.bit_set && !i_stat.page_full) begin
                    o_cmd.bit_calc = 1'b1;
                    n_state = S_CHK;
                end else begin
                    o_cmd.bit_next = 1'b1;
                    if (i_stat.bit_last) n_state = S_ADV;
                end
            end
            S_CHK: begin
                if (i_stat.idx_out) begin
                    o_cmd.drop     = 1'b1;
                    o_cmd.bit_next = 1'b1;
                    n_state = i_stat.bit_last ? S_ADV : S_BIT;
                end else begin
                    o_cmd.mem_rd = 1'b1;
                    n_state = S_WR;
                end
            end
            S_WR: begin
                o_cmd.mem_wr   = 1'b1;
                o_cmd.bit_next = 1'b1;
                n_state = i_stat.bit_last ? S_ADV : S_BIT;
            end
            S_ADV: begin
                o_cmd.advance = 1'b1;
                n_state = S_DONE;
            end
            S_RD: begin
                o_cmd.read_issue = 1'b1;
                n_state = S_RDW;
            end
            S_RDW: begin
                o_cmd.read_take = 1'b1;
                n_state = S_DONE;
            end
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // hold state; a reset clears the store without reporting a beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_report <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.accept) r_report <= 1'b1;
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = (r_state == S_DONE);

endmodule

### design/vertical_glyph_string_rasterizer.sv
// ----------------------------------------------------------------------------
// vertical_glyph_string_rasterizer: top level
// Builds a row-major 1-bit string bitmap from vertical-page glyph bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive i_req and raise i_start; the beat is taken at an
//   edge where i_start is high and o_busy is low.
//   Result channel: o_done is high for exactly one cycle with o_res valid;
//   the receiver cannot stall, so it must take the beat in that cycle.
//   Configuration: i_cfg_we with i_cfg_data writes the glyph gap; write it
//   only while the block is idle.
// Steps (accept to o_done):
//   clear: one store byte cleared per cycle;
//   declare: the glyph is entered in the tables; read: one store byte;
//   data byte: empty glyphs are skipped, and with no pending glyph the
//   request reports no data; otherwise each bit is passed over (clear or
//   on the last page), dropped (outside the store) or set by a
//   read-modify-write of the store.
// One request is in flight at a time; the store ports and the per-pixel
// read-modify-write set the rate.
// Reset: counters clear and the store is swept to zero with o_busy high;
// no result beat is produced for it.
// ----------------------------------------------------------------------------
module vertical_glyph_string_rasterizer
    import vgsr_pkg::*;
#(
    parameter int BITMAP_BYTES = 4096,
    parameter int MAX_GLYPHS   = 128
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  t_req       i_req,
    output logic       o_busy,
    output logic       o_done,
    output t_res       o_res,
    input  logic       i_cfg_we,
    input  logic [3:0] i_cfg_data
);
    t_cmd  cmd;
    t_stat stat;

    vgsr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (o_busy),
        .o_done  (o_done)
    );

    vgsr_dp #(
        .BITMAP_BYTES (BITMAP_BYTES),
        .MAX_GLYPHS   (MAX_GLYPHS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (i_req),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_res      (o_res)
    );

`ifndef NO_ASSERTIONS
    // a result beat is always followed by an idle cycle
    a_done_then_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_busy)
        else $error("block not idle after result beat");

    // a failed request returns no store data
    a_rdata_only_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_res.status != ST_OK) |-> (o_res.read_data == 8'h00))
        else $error("read data on a failed request");

    // an accepted request always leaves the idle state
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("accepted request did not start");
`endif

endmodule
